// ----- design/blrpg_pkg.sv -----
`default_nettype none

package blrpg_pkg;

  localparam int unsigned CFG_W       = 12;
  localparam int unsigned PIX_COORD_W = 12;
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] H_RES_RESET = 12'd1024;
  localparam logic [CFG_W-1:0] V_RES_RESET = 12'd768;

  // configuration register indexes
  typedef enum logic {
    CFG_H_RES = 1'b0,
    CFG_V_RES = 1'b1
  } cfg_idx_e;

  // request type codes on the input channel
  localparam logic [1:0] REQ_LINE = 2'd0;
  localparam logic [1:0] REQ_RECT = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // classified entry kinds between front and back
  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_RECT,
    KIND_REJECT,
    KIND_TICK
  } kind_e;

endpackage

`default_nettype wire

// ----- design/blrpg_if.sv -----
`default_nettype none

interface blrpg_req_if #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned COLOR_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [COORD_BITS-1:0] rect_width;
  logic [COORD_BITS-1:0] rect_height;
  logic [COLOR_BITS-1:0] color;

  modport source (
    output valid, req_type, x_start, y_start, x_end, y_end, rect_width, rect_height, color,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_start, y_start, x_end, y_end, rect_width, rect_height, color,
    output ready
  );
endinterface

interface blrpg_pix_if #(
  parameter int unsigned COLOR_BITS = 8
);
  import blrpg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PIX_COORD_W-1:0] pixel_x;
  logic [PIX_COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]      pixel_address;
  logic [COLOR_BITS-1:0]  pixel_color;
  logic                   on_screen;
  logic                   last;
  logic                   rect_error;

  modport source (
    output valid, pixel_x, pixel_y, pixel_address, pixel_color, on_screen, last, rect_error,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_address, pixel_color, on_screen, last, rect_error,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/blrpg_front.sv -----
`default_nettype none

module blrpg_front #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned COLOR_BITS = 8
) (
  blrpg_req_if.sink                     req_i,
  input  logic [blrpg_pkg::CFG_W-1:0]   h_res_i,
  input  logic [blrpg_pkg::CFG_W-1:0]   v_res_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output blrpg_pkg::kind_e              kind_o,
  output logic [COORD_BITS:0]           x0_o,
  output logic [COORD_BITS:0]           y0_o,
  output logic [COORD_BITS:0]           x1_o,
  output logic [COORD_BITS:0]           y1_o,
  output logic [COLOR_BITS-1:0]         color_o
);
  import blrpg_pkg::*;

  localparam int unsigned CW    = COORD_BITS + 1;
  localparam int unsigned SUM_W = (CW > CFG_W) ? CW : CFG_W;

  logic [SUM_W-1:0] x_far;
  logic [SUM_W-1:0] y_far;
  logic             reject;
  logic             is_rect;

  assign req_i.ready = !q_full_i;
  // type three carries nothing, it is taken and dropped here
  assign q_push_o = req_i.valid && !q_full_i &&
                    (req_i.req_type inside {REQ_LINE, REQ_RECT, REQ_TICK});

  assign x_far   = SUM_W'(req_i.x_start) + SUM_W'(req_i.rect_width);
  assign y_far   = SUM_W'(req_i.y_start) + SUM_W'(req_i.rect_height);
  assign reject  = (x_far > SUM_W'(h_res_i)) || (y_far > SUM_W'(v_res_i));
  assign is_rect = (req_i.req_type == REQ_RECT);

  always_comb begin
    case (req_i.req_type)
      REQ_LINE: kind_o = KIND_LINE;
      REQ_RECT: kind_o = reject ? KIND_REJECT : KIND_RECT;
      default:  kind_o = KIND_TICK;
    endcase
  end

  // rectangles carry their far corner instead of the size
  assign x0_o    = CW'(req_i.x_start);
  assign y0_o    = CW'(req_i.y_start);
  assign x1_o    = is_rect ? CW'(req_i.x_start) + CW'(req_i.rect_width)  : CW'(req_i.x_end);
  assign y1_o    = is_rect ? CW'(req_i.y_start) + CW'(req_i.rect_height) : CW'(req_i.y_end);
  assign color_o = req_i.color;

endmodule

`default_nettype wire

// ----- design/blrpg_fifo.sv -----
`default_nettype none

module blrpg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/blrpg_step.sv -----
`default_nettype none

module blrpg_step #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  entry_valid_i,
  input  blrpg_pkg::kind_e      kind_i,
  input  logic [COORD_BITS:0]   x0_i,
  input  logic [COORD_BITS:0]   y0_i,
  input  logic [COORD_BITS:0]   x1_i,
  input  logic [COORD_BITS:0]   y1_i,
  input  logic [COLOR_BITS-1:0] color_i,
  output logic                  pop_o,
  input  logic                  res_ready_i,
  output logic                  res_valid_o,
  output logic [COORD_BITS:0]   res_x_o,
  output logic [COORD_BITS:0]   res_y_o,
  output logic [COLOR_BITS-1:0] res_color_o,
  output logic                  res_last_o,
  output logic                  res_reject_o
);
  import blrpg_pkg::*;

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned EW = COORD_BITS + 3;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [1:0] SIDE_LEFT   = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  typedef struct packed {
    logic [CW-1:0]        cur_x;
    logic [CW-1:0]        cur_y;
    logic [CW-1:0]        end_x;
    logic [CW-1:0]        end_y;
    logic [CW-1:0]        dx;
    logic [CW-1:0]        dy;
    logic                 x_neg;
    logic                 y_neg;
    logic signed [EW-1:0] err;
  } line_t;

  function automatic line_t setup_line(input logic [CW-1:0] xi, input logic [CW-1:0] yi,
                                       input logic [CW-1:0] xf, input logic [CW-1:0] yf);
    line_t l;
    l.cur_x = xi;
    l.cur_y = yi;
    l.end_x = xf;
    l.end_y = yf;
    l.x_neg = !(xi < xf);
    l.y_neg = !(yi < yf);
    l.dx    = (xi < xf) ? xf - xi : xi - xf;
    l.dy    = (yi < yf) ? yf - yi : yi - yf;
    // half the major delta, sign set by which axis leads
    l.err   = (l.dx > l.dy) ? $signed(EW'(l.dx >> 1)) : $signed(EW'(0) - EW'(l.dy >> 1));
    return l;
  endfunction

  function automatic line_t side_line(input logic [1:0] side,
                                      input logic [CW-1:0] x0, input logic [CW-1:0] y0,
                                      input logic [CW-1:0] x1, input logic [CW-1:0] y1);
    line_t l;
    case (side)
      SIDE_TOP:    l = setup_line(x0, y0, x1, y0);
      SIDE_BOTTOM: l = setup_line(x0, y1, x1, y1);
      SIDE_LEFT:   l = setup_line(x0, y0, x0, y1);
      default:     l = setup_line(x1, y0, x1, y1);
    endcase
    return l;
  endfunction

  line_t                 line_q, line_d;
  logic                  busy_q, busy_d;
  logic                  rect_q, rect_d;
  logic [1:0]            side_q, side_d;
  logic [COLOR_BITS-1:0] color_q, color_d;
  logic [CW-1:0]         cx0_q, cy0_q, cx1_q, cy1_q;
  logic [CW-1:0]         cx0_d, cy0_d, cx1_d, cy1_d;

  logic                  res_valid_q;
  logic [CW-1:0]         res_x_q, res_y_q;
  logic [COLOR_BITS-1:0] res_color_q;
  logic                  res_last_q, res_reject_q;

  logic                  adv;
  logic                  emit;
  logic [CW-1:0]         out_x, out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last, out_reject;
  logic signed [EW-1:0]  dx_s, dy_s;
  logic                  step_x, step_y;

  assign adv   = !res_valid_q || res_ready_i;
  assign pop_o = entry_valid_i && adv;

  assign dx_s   = $signed(EW'(line_q.dx));
  assign dy_s   = $signed(EW'(line_q.dy));
  assign step_x = line_q.err > -dx_s;
  assign step_y = line_q.err < dy_s;

  always_comb begin
    line_d     = line_q;
    busy_d     = busy_q;
    rect_d     = rect_q;
    side_d     = side_q;
    color_d    = color_q;
    cx0_d      = cx0_q;
    cy0_d      = cy0_q;
    cx1_d      = cx1_q;
    cy1_d      = cy1_q;
    emit       = 1'b0;
    out_x      = line_q.cur_x;
    out_y      = line_q.cur_y;
    out_color  = color_q;
    out_last   = 1'b0;
    out_reject = 1'b0;
    if (pop_o) begin
      case (kind_i)
        KIND_LINE: begin
          if (!busy_q) begin
            rect_d  = 1'b0;
            side_d  = SIDE_TOP;
            color_d = color_i;
            line_d  = setup_line(x0_i, y0_i, x1_i, y1_i);
            busy_d  = 1'b1;
          end
        end
        KIND_RECT: begin
          if (!busy_q) begin
            rect_d  = 1'b1;
            side_d  = SIDE_TOP;
            color_d = color_i;
            cx0_d   = x0_i;
            cy0_d   = y0_i;
            cx1_d   = x1_i;
            cy1_d   = y1_i;
            line_d  = side_line(SIDE_TOP, x0_i, y0_i, x1_i, y1_i);
            busy_d  = 1'b1;
          end
        end
        KIND_REJECT: begin
          if (!busy_q) begin
            emit       = 1'b1;
            out_x      = '0;
            out_y      = '0;
            out_color  = '0;
            out_last   = 1'b1;
            out_reject = 1'b1;
          end
        end
        KIND_TICK: begin
          if (busy_q) begin
            emit = 1'b1;
            if (line_q.cur_x == line_q.end_x && line_q.cur_y == line_q.end_y) begin
              if (rect_q && side_q != SIDE_RIGHT) begin
                side_d = side_q + 1'b1;
                line_d = side_line(side_d, cx0_q, cy0_q, cx1_q, cy1_q);
              end else begin
                busy_d   = 1'b0;
                rect_d   = 1'b0;
                out_last = 1'b1;
              end
            end else begin
              line_d.err = line_q.err - (step_x ? dy_s : EW'(0)) + (step_y ? dx_s : EW'(0));
              if (step_x) begin
                line_d.cur_x = line_q.x_neg ? line_q.cur_x - 1'b1 : line_q.cur_x + 1'b1;
              end
              if (step_y) begin
                line_d.cur_y = line_q.y_neg ? line_q.cur_y - 1'b1 : line_q.cur_y + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      busy_q      <= 1'b0;
      rect_q      <= 1'b0;
      side_q      <= SIDE_TOP;
      color_q     <= '0;
      cx0_q       <= '0;
      cy0_q       <= '0;
      cx1_q       <= '0;
      cy1_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      line_q  <= line_d;
      busy_q  <= busy_d;
      rect_q  <= rect_d;
      side_q  <= side_d;
      color_q <= color_d;
      cx0_q   <= cx0_d;
      cy0_q   <= cy0_d;
      cx1_q   <= cx1_d;
      cy1_q   <= cy1_d;
      if (adv) begin
        res_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      res_x_q      <= out_x;
      res_y_q      <= out_y;
      res_color_q  <= out_color;
      res_last_q   <= out_last;
      res_reject_q <= out_reject;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_x_o      = res_x_q;
  assign res_y_o      = res_y_q;
  assign res_color_o  = res_color_q;
  assign res_last_o   = res_last_q;
  assign res_reject_o = res_reject_q;

endmodule

`default_nettype wire

// ----- design/blrpg_pixout.sv -----
`default_nettype none

module blrpg_pixout #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [blrpg_pkg::CFG_W-1:0] h_res_i,
  input  logic [blrpg_pkg::CFG_W-1:0] v_res_i,
  input  logic                        res_valid_i,
  output logic                        res_ready_o,
  input  logic [COORD_BITS:0]         res_x_i,
  input  logic [COORD_BITS:0]         res_y_i,
  input  logic [COLOR_BITS-1:0]       res_color_i,
  input  logic                        res_last_i,
  input  logic                        res_reject_i,
  blrpg_pix_if.source                 pix_o
);
  import blrpg_pkg::*;

  localparam int unsigned CW    = COORD_BITS + 1;
  localparam int unsigned MUL_W = CW + CFG_W;
  localparam int unsigned CMP_W = (CW > CFG_W) ? CW : CFG_W;

  logic                   valid_q;
  logic [PIX_COORD_W-1:0] x_q, y_q;
  logic [ADDR_W-1:0]      addr_q, addr_d;
  logic [COLOR_BITS-1:0]  color_q;
  logic                   on_q, on_d;
  logic                   last_q, reject_q;
  logic                   load;

  assign res_ready_o = !valid_q || pix_o.ready;
  assign load        = res_valid_i && res_ready_o;

  // row times pitch plus column, kept modulo the address width
  assign addr_d = ADDR_W'(MUL_W'(res_y_i) * MUL_W'(h_res_i) + MUL_W'(res_x_i));
  assign on_d   = !res_reject_i && (CMP_W'(res_x_i) < CMP_W'(h_res_i)) &&
                  (CMP_W'(res_y_i) < CMP_W'(v_res_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q      <= PIX_COORD_W'(res_x_i);
      y_q      <= PIX_COORD_W'(res_y_i);
      addr_q   <= addr_d;
      color_q  <= res_color_i;
      on_q     <= on_d;
      last_q   <= res_last_i;
      reject_q <= res_reject_i;
    end
  end

  assign pix_o.valid         = valid_q;
  assign pix_o.pixel_x       = x_q;
  assign pix_o.pixel_y       = y_q;
  assign pix_o.pixel_address = addr_q;
  assign pix_o.pixel_color   = color_q;
  assign pix_o.on_screen     = on_q;
  assign pix_o.last          = last_q;
  assign pix_o.rect_error    = reject_q;

endmodule

`default_nettype wire

// ----- design/bresenham_line_rect_pixel_generator_core.sv -----
`default_nettype none
// channel  | dir | handshake     | carries
// ---------+-----+---------------+------------------------------------------
// req_i    | in  | valid / ready | line, rectangle or tick request
// pix_o    | out | valid / ready | one pixel or a rectangle rejection
// cfg      | in  | cfg_we_i only | h_res (index 0), v_res (index 1)
//
// sustained rate is one request per clock while the queue is not full
// throughput is set by the single bresenham step register in the back end
// a four entry queue sits between classification and drawing, so each side stalls alone
// reset clears the queue, the drawing state and the output valid; resolutions go to 1024x768

module bresenham_line_rect_pixel_generator_core #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [blrpg_pkg::CFG_W-1:0] cfg_data_i,
  blrpg_req_if.sink                   req_i,
  blrpg_pix_if.source                 pix_o
);
  import blrpg_pkg::*;

  localparam int unsigned CW      = COORD_BITS + 1;
  localparam int unsigned ENTRY_W = 2 + 4 * CW + COLOR_BITS;

  logic [CFG_W-1:0]      h_res_q, v_res_q;

  logic                  q_push, q_full, q_pop, q_valid;
  kind_e                 f_kind;
  logic [CW-1:0]         f_x0, f_y0, f_x1, f_y1;
  logic [COLOR_BITS-1:0] f_color;
  logic [ENTRY_W-1:0]    q_wdata, q_rdata;

  kind_e                 b_kind;
  logic [CW-1:0]         b_x0, b_y0, b_x1, b_y1;
  logic [COLOR_BITS-1:0] b_color;

  logic                  res_valid, res_ready;
  logic [CW-1:0]         res_x, res_y;
  logic [COLOR_BITS-1:0] res_color;
  logic                  res_last, res_reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_res_q <= H_RES_RESET;
      v_res_q <= V_RES_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_H_RES) begin
        h_res_q <= cfg_data_i;
      end else begin
        v_res_q <= cfg_data_i;
      end
    end
  end

  blrpg_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .req_i    (req_i),
    .h_res_i  (h_res_q),
    .v_res_i  (v_res_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .kind_o   (f_kind),
    .x0_o     (f_x0),
    .y0_o     (f_y0),
    .x1_o     (f_x1),
    .y1_o     (f_y1),
    .color_o  (f_color)
  );

  assign q_wdata = {f_kind, f_x0, f_y0, f_x1, f_y1, f_color};

  blrpg_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign b_kind  = kind_e'(q_rdata[ENTRY_W-1 -: 2]);
  assign b_x0    = q_rdata[COLOR_BITS + 4*CW - 1 -: CW];
  assign b_y0    = q_rdata[COLOR_BITS + 3*CW - 1 -: CW];
  assign b_x1    = q_rdata[COLOR_BITS + 2*CW - 1 -: CW];
  assign b_y1    = q_rdata[COLOR_BITS + CW - 1 -: CW];
  assign b_color = q_rdata[COLOR_BITS-1:0];

  blrpg_step #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .kind_i        (b_kind),
    .x0_i          (b_x0),
    .y0_i          (b_y0),
    .x1_i          (b_x1),
    .y1_i          (b_y1),
    .color_i       (b_color),
    .pop_o         (q_pop),
    .res_ready_i   (res_ready),
    .res_valid_o   (res_valid),
    .res_x_o       (res_x),
    .res_y_o       (res_y),
    .res_color_o   (res_color),
    .res_last_o    (res_last),
    .res_reject_o  (res_reject)
  );

  blrpg_pixout #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_pixout (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .h_res_i      (h_res_q),
    .v_res_i      (v_res_q),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_x_i      (res_x),
    .res_y_i      (res_y),
    .res_color_i  (res_color),
    .res_last_i   (res_last),
    .res_reject_i (res_reject),
    .pix_o        (pix_o)
  );

endmodule

`default_nettype wire
